// ===== hdl/first_fit_coalescing_allocator_core_assert.svh =====
// assertion macros for the allocator core
`ifndef FIRST_FIT_COALESCING_ALLOCATOR_CORE_ASSERT_SVH
`define FIRST_FIT_COALESCING_ALLOCATOR_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define FFCA_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define FFCA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define FFCA_ASSERT(label, clk, rst_n, prop, msg)
`define FFCA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== hdl/ffca_pkg.sv =====
package ffca_pkg;

  localparam int unsigned MaxExtentsDefault = 64;
  localparam int unsigned AddrBitsDefault = 20;
  localparam int unsigned LenW = 21;
  localparam logic [LenW-1:0] LenMax = 21'h1FFFFE;
  localparam logic [LenW-1:0] ArenaReset = 21'd65536;
  localparam logic [LenW-1:0] SlackLimit = 21'd2;

  localparam logic [1:0] StOk = 2'd0;
  localparam logic [1:0] StOom = 2'd1;
  localparam logic [1:0] StFull = 2'd2;

  localparam logic ActAlloc = 1'b0;
  localparam logic ActRelease = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_A_RD,
    S_A_CHK,
    S_A_SHIFT,
    S_R_RD,
    S_R_CHK,
    S_R_SUCC,
    S_R_MERGE,
    S_R_INS,
    S_DONE
  } state_e;

  function automatic logic [LenW-1:0] sat_len(input logic [LenW:0] v);
    sat_len = (v > {1'b0, LenMax}) ? LenMax : v[LenW-1:0];
  endfunction

endpackage

// ===== hdl/first_fit_coalescing_allocator_core.sv =====
// First-fit word allocator with a sorted free-extent table and a bump region.
// Input channel s_axis: tdata = {block_base, keep_header, size_words}, tuser =
// action (0 allocate, 1 release). Output channel m_axis: tdata = {granted_words,
// block_address, user_address}, tuser = status (0 ok, 1 out of memory, 2 table
// full). cfg_valid_i/cfg_data_i write arena_words; the user must do so only while
// the block is idle, which the block does not enforce. One item is taken at a time:
// s_axis_tready is high only when the core is idle and no result waits. The table
// lives in one single-port memory that is walked one entry per step (read, then
// compare). An allocate takes the first extent that fits, else the bump region;
// an exact fit (or, with keep_header, a slack of at most 2 words) removes the
// extent and pulls the entries behind it down. A release walks to the insertion
// point, then merges with a neighbour or shifts the tail up to insert; a merge
// on both sides removes the later entry. The result sits in an output register
// until m_axis_tready; the core then becomes ready again. Reset empties the
// table (count zero), clears the bump pointer and sets arena_words to 65536.
// No clearing pass is needed: entries at or above the count are never read.
`include "first_fit_coalescing_allocator_core_assert.svh"
module first_fit_coalescing_allocator_core #(
  parameter int unsigned MAX_EXTENTS = ffca_pkg::MaxExtentsDefault,
  parameter int unsigned ADDR_BITS = ffca_pkg::AddrBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // size_words[20:0], keep_header[21], block_base[41:22]
  input  logic        s_axis_tuser,  // action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,  // user_address[19:0], block_address[39:20], granted_words[60:40]
  output logic [1:0]  m_axis_tuser,  // status
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [20:0] cfg_data_i     // arena_words
);
  localparam int unsigned LenW = ffca_pkg::LenW;
  localparam int unsigned IdxW = $clog2(MAX_EXTENTS);
  localparam int unsigned CntW = $clog2(MAX_EXTENTS + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_EXTENTS);

  ffca_pkg::state_e state_q, state_d;

  logic [ADDR_BITS-1:0] mem_base [MAX_EXTENTS];
  logic [LenW-1:0]      mem_len  [MAX_EXTENTS];

  logic [CntW-1:0] count_q, count_d;
  logic [LenW-1:0] bump_q, bump_d, arena_q;
  logic [CntW-1:0] idx_q, idx_d;
  logic [ADDR_BITS-1:0] rd_base_q;
  logic [LenW-1:0] rd_len_q;
  logic [ADDR_BITS-1:0] carry_base_q, carry_base_d;
  logic [LenW-1:0] carry_len_q, carry_len_d;
  logic [LenW-1:0] n_q, n_d;
  logic hdr_q, hdr_d, act_q;
  logic [ADDR_BITS-1:0] base_q, base_d;
  logic [ADDR_BITS-1:0] pbase_q, pbase_d;
  logic [LenW-1:0] plen_q, plen_d;
  logic pvalid_q, pvalid_d;

  logic out_valid_q, out_valid_d;
  logic [1:0] st_q, st_d;
  logic [ADDR_BITS-1:0] blk_q, blk_d;
  logic [LenW-1:0] gw_q, gw_d;

  // memory port control
  logic rd_en;
  logic [IdxW-1:0] rd_addr;
  logic wr_en;
  logic [IdxW-1:0] wr_addr;
  logic [ADDR_BITS-1:0] wr_base;
  logic [LenW-1:0] wr_len;

  logic in_acc;
  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ffca_pkg::S_IDLE) && !out_valid_q;
  assign cfg_ready_o = 1'b1;

  // adders for the release merge checks
  logic [LenW:0] end_sum;
  logic [LenW:0] base_n;
  assign end_sum = {1'b0, LenW'(pbase_q)} + {1'b0, plen_q};
  assign base_n = {1'b0, LenW'(base_q)} + {1'b0, n_q};

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_base[wr_addr] <= wr_base;
      mem_len[wr_addr] <= wr_len;
    end
    if (rd_en) begin
      rd_base_q <= mem_base[rd_addr];
      rd_len_q <= mem_len[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ffca_pkg::S_IDLE;
      count_q <= '0;
      bump_q <= '0;
      arena_q <= ffca_pkg::ArenaReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      bump_q <= bump_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) arena_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    n_q <= n_d;
    hdr_q <= hdr_d;
    base_q <= base_d;
    pbase_q <= pbase_d;
    plen_q <= plen_d;
    pvalid_q <= pvalid_d;
    carry_base_q <= carry_base_d;
    carry_len_q <= carry_len_d;
    st_q <= st_d;
    blk_q <= blk_d;
    gw_q <= gw_d;
    if (in_acc) act_q <= s_axis_tuser;
  end

  logic [LenW:0] req_n;
  logic [LenW-1:0] slack;
  logic [LenW:0] room;
  always_comb begin
    req_n = {1'b0, s_axis_tdata[20:0]} + {{LenW{1'b0}}, s_axis_tdata[21]};
    req_n = req_n + {{LenW{1'b0}}, req_n[0]};
    slack = rd_len_q - n_q;
    room = (bump_q <= arena_q) ? {1'b0, arena_q - bump_q} : '0;
  end

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    bump_d = bump_q;
    idx_d = idx_q;
    n_d = n_q;
    hdr_d = hdr_q;
    base_d = base_q;
    pbase_d = pbase_q;
    plen_d = plen_q;
    pvalid_d = pvalid_q;
    carry_base_d = carry_base_q;
    carry_len_d = carry_len_q;
    st_d = st_q;
    blk_d = blk_q;
    gw_d = gw_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    rd_en = 1'b0;
    rd_addr = idx_q[IdxW-1:0];
    wr_en = 1'b0;
    wr_addr = idx_q[IdxW-1:0];
    wr_base = carry_base_q;
    wr_len = carry_len_q;
    case (state_q)
      ffca_pkg::S_IDLE: begin
        if (in_acc) begin
          idx_d = '0;
          hdr_d = s_axis_tdata[21];
          base_d = ADDR_BITS'(s_axis_tdata[41:22]);
          pvalid_d = 1'b0;
          st_d = ffca_pkg::StOk;
          blk_d = '0;
          gw_d = '0;
          if (s_axis_tuser == ffca_pkg::ActAlloc) begin
            n_d = req_n[LenW-1:0];
            // a request past the largest length can never fit
            if (req_n[LenW]) begin
              st_d = ffca_pkg::StOom;
              state_d = ffca_pkg::S_DONE;
            end else begin
              state_d = ffca_pkg::S_A_RD;
            end
          end else begin
            n_d = ffca_pkg::sat_len({1'b0, s_axis_tdata[20:0]} +
                                    {{LenW{1'b0}}, s_axis_tdata[0]});
            if (s_axis_tdata[20:0] == '0) state_d = ffca_pkg::S_DONE;
            else state_d = ffca_pkg::S_R_RD;
          end
        end
      end
      ffca_pkg::S_A_RD: begin
        if (idx_q < count_q) begin
          rd_en = 1'b1;
          state_d = ffca_pkg::S_A_CHK;
        end else if (room < {1'b0, n_q}) begin
          st_d = ffca_pkg::StOom;
          state_d = ffca_pkg::S_DONE;
        end else begin
          blk_d = bump_q[ADDR_BITS-1:0];
          gw_d = n_q;
          bump_d = bump_q + n_q;
          state_d = ffca_pkg::S_DONE;
        end
      end
      ffca_pkg::S_A_CHK: begin
        if (rd_len_q < n_q) begin
          idx_d = idx_q + 1'b1;
          state_d = ffca_pkg::S_A_RD;
        end else if (rd_len_q == n_q || (hdr_q && slack <= ffca_pkg::SlackLimit)) begin
          blk_d = rd_base_q;
          gw_d = rd_len_q;
          idx_d = idx_q + 1'b1;
          state_d = ffca_pkg::S_A_SHIFT;
        end else begin
          wr_en = 1'b1;
          wr_base = rd_base_q;
          wr_len = slack;
          blk_d = rd_base_q + ADDR_BITS'(slack);
          gw_d = n_q;
          state_d = ffca_pkg::S_DONE;
        end
      end
      ffca_pkg::S_A_SHIFT: begin
        // pull entries down one slot; rd data holds entry idx-1 on writes
        if (pvalid_q) begin
          wr_en = 1'b1;
          wr_addr = IdxW'(idx_q - 2'd2);
          wr_base = rd_base_q;
          wr_len = rd_len_q;
          pvalid_d = 1'b0;
        end else if (idx_q < count_q) begin
          rd_en = 1'b1;
          idx_d = idx_q + 1'b1;
          pvalid_d = 1'b1;
        end else begin
          count_d = count_q - 1'b1;
          state_d = ffca_pkg::S_DONE;
        end
      end
      ffca_pkg::S_R_RD: begin
        if (idx_q < count_q) begin
          rd_en = 1'b1;
          state_d = ffca_pkg::S_R_CHK;
        end else begin
          state_d = ffca_pkg::S_R_SUCC;
        end
      end
      ffca_pkg::S_R_CHK: begin
        if (rd_base_q <= base_q) begin
          pbase_d = rd_base_q;
          plen_d = rd_len_q;
          pvalid_d = 1'b1;
          idx_d = idx_q + 1'b1;
          state_d = ffca_pkg::S_R_RD;
        end else begin
          state_d = ffca_pkg::S_R_SUCC;
        end
      end
      ffca_pkg::S_R_SUCC: begin
        // idx = pos, rd data = entry pos when pos < count
        if (pvalid_q && end_sum == {1'b0, LenW'(base_q)}) begin
          plen_d = ffca_pkg::sat_len({1'b0, plen_q} + {1'b0, n_q});
          wr_en = 1'b1;
          wr_addr = IdxW'(idx_q - 1'b1);
          wr_base = pbase_q;
          wr_len = plen_d;
          if (idx_q < count_q &&
              end_sum + {1'b0, n_q} == {1'b0, LenW'(rd_base_q)}) begin
            state_d = ffca_pkg::S_R_MERGE;
          end else begin
            state_d = ffca_pkg::S_DONE;
          end
        end else if (idx_q < count_q && base_n == {1'b0, LenW'(rd_base_q)}) begin
          wr_en = 1'b1;
          wr_base = base_q;
          wr_len = ffca_pkg::sat_len({1'b0, rd_len_q} + {1'b0, n_q});
          state_d = ffca_pkg::S_DONE;
        end else if (count_q >= CntMax) begin
          st_d = ffca_pkg::StFull;
          state_d = ffca_pkg::S_DONE;
        end else begin
          carry_base_d = base_q;
          carry_len_d = n_q;
          pvalid_d = 1'b0;
          state_d = ffca_pkg::S_R_INS;
        end
      end
      ffca_pkg::S_R_MERGE: begin
        wr_en = 1'b1;
        wr_addr = IdxW'(idx_q - 1'b1);
        wr_base = pbase_q;
        wr_len = ffca_pkg::sat_len({1'b0, plen_q} + {1'b0, rd_len_q});
        idx_d = idx_q + 1'b1;
        pvalid_d = 1'b0;
        state_d = ffca_pkg::S_A_SHIFT;
      end
      ffca_pkg::S_R_INS: begin
        // ripple: read old entry, write carried one, carry the old
        if (!pvalid_q) begin
          if (idx_q < count_q) rd_en = 1'b1;
          pvalid_d = 1'b1;
        end else begin
          wr_en = 1'b1;
          carry_base_d = rd_base_q;
          carry_len_d = rd_len_q;
          pvalid_d = 1'b0;
          if (idx_q >= count_q) begin
            count_d = count_q + 1'b1;
            state_d = ffca_pkg::S_DONE;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      ffca_pkg::S_DONE: begin
        out_valid_d = 1'b1;
        state_d = ffca_pkg::S_IDLE;
      end
      default: state_d = ffca_pkg::S_IDLE;
    endcase
  end

  logic [ADDR_BITS-1:0] ua;
  assign ua = blk_q + ADDR_BITS'(hdr_q && act_q == ffca_pkg::ActAlloc &&
                                 st_q == ffca_pkg::StOk);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser = st_q;
  always_comb begin
    m_axis_tdata = '0;
    m_axis_tdata[19:0] = 20'(ua);
    m_axis_tdata[39:20] = 20'(blk_q);
    m_axis_tdata[60:40] = gw_q;
  end

  `FFCA_ASSERT(a_count_bound, clk_i, rst_ni, (count_q <= CntMax), "extent count overflow")
  `FFCA_ASSERT_NEXT(a_busy_not_ready, clk_i, rst_ni, in_acc, !s_axis_tready,
    "accepted a second item while busy")
  `FFCA_ASSERT_NEXT(a_done_valid, clk_i, rst_ni, state_q == ffca_pkg::S_DONE, m_axis_tvalid,
    "result not presented after done")
endmodule
